FILE: sv/ccc_pkg.sv
// Shared types and constants for the charge connector controller.
package ccc_pkg;

  localparam int METER_WIDTH_DEF = 48;

  localparam int RATE_W    = 20;
  localparam int START_W   = 48;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int AMOUNT_W  = 27;
  localparam int AUTH_W    = 17;

  localparam logic [TIMEOUT_W-1:0] AUTH_TIMEOUT_RST = 16'd10000;

  // floor(ms / 1000) = floor((ms >> 3) * MS_RECIP >> MS_SHIFT) for 16-bit ms
  localparam logic [13:0] MS_RECIP = 14'd8389;
  localparam int          MS_SHIFT = 20;
  localparam int          SEC_W    = 7;
  localparam logic [9:0]  MS_PER_S = 10'd1000;

  // floor(z / 1000) = floor((z >> 3) * Z_RECIP >> Z_SHIFT) for 30-bit z
  localparam logic [27:0] Z_RECIP = 28'd137438954;
  localparam int          Z_SHIFT = 34;
  localparam int          FRAC_W  = 20;

  localparam logic [RATE_W-1:0] PWR_LVL_HI  = 20'd2000;
  localparam logic [RATE_W-1:0] PWR_LVL_MID = 20'd1000;
  localparam logic [RATE_W-1:0] PWR_LVL_LO  = 20'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE         = 2'd0,
    CFG_METER_START  = 2'd1,
    CFG_AUTH_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_POWER_GOOD  = 3'd0,
    MODE_POWER_FAULT = 3'd1,
    MODE_ENROLL      = 3'd2,
    MODE_PLUG_IN     = 3'd3,
    MODE_UNPLUG      = 3'd4,
    MODE_FORCE_STOP  = 3'd5,
    MODE_TICK        = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_UNDEF    = 3'd0,
    ST_ONPOST   = 3'd1,
    ST_AUTH     = 3'd2,
    ST_CHARGING = 3'd3,
    ST_PLUGGED  = 3'd4,
    ST_DONE     = 3'd5,
    ST_FAULT    = 3'd6
  } conn_state_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [31:0]       session_number;
    logic [31:0]       session_cap;
    logic [15:0]       elapsed_ms;
    logic [RATE_W-1:0] car_power;
  } item_t;

  typedef struct packed {
    logic [2:0]          connector_state;
    logic                auth_cleared;
    logic [AMOUNT_W-1:0] delivered;
    logic [47:0]         meter_total;
    logic [31:0]         session_energy;
    logic [31:0]         session_out;
  } result_t;

endpackage

FILE: sv/ccc_scale.sv
// Energy scaling pipeline: floor(rate * ms / 1000) downscaled by car power.
module ccc_scale (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ccc_pkg::RATE_W-1:0]      rate,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  ccc_pkg::item_t                  item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ccc_pkg::item_t                  out_item,
  output logic [ccc_pkg::AMOUNT_W-1:0]    out_amount
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  ccc_pkg::item_t item0, item1, item2, item3, item4;
  logic [ccc_pkg::SEC_W-1:0]    secs1, secs2;
  logic [9:0]                   msrem2;
  logic [ccc_pkg::AMOUNT_W-1:0] whole3;
  logic [29:0]                  frac3;
  logic [ccc_pkg::AMOUNT_W-1:0] amount4;

  logic [26:0]                  ms_prod;
  logic [16:0]                  ms_back;
  logic [54:0]                  z_prod;
  logic [ccc_pkg::FRAC_W-1:0]   frac_q;
  logic [ccc_pkg::AMOUNT_W-1:0] raw;
  logic [ccc_pkg::AMOUNT_W-1:0] scaled;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign item_ready = adv[0];
  assign out_valid  = vld[NSTG-1];
  assign out_item   = item4;
  assign out_amount = amount4;

  always_comb begin
    ms_prod = 27'(item0.elapsed_ms[15:3]) * 27'(ccc_pkg::MS_RECIP);
    ms_back = 17'(secs1) * 17'(ccc_pkg::MS_PER_S);
    z_prod  = 55'(frac3[29:3]) * 55'(ccc_pkg::Z_RECIP);
    frac_q  = z_prod[ccc_pkg::Z_SHIFT +: ccc_pkg::FRAC_W];
    raw     = whole3 + ccc_pkg::AMOUNT_W'(frac_q);
    scaled  = raw;
    if (item3.car_power < ccc_pkg::PWR_LVL_HI)  scaled = scaled >> 1;
    if (item3.car_power < ccc_pkg::PWR_LVL_MID) scaled = scaled >> 1;
    if (item3.car_power < ccc_pkg::PWR_LVL_LO)  scaled = scaled >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= item_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      item0 <= item;
    end
    if (adv[1]) begin
      item1 <= item0;
      secs1 <= ms_prod[ccc_pkg::MS_SHIFT +: ccc_pkg::SEC_W];
    end
    if (adv[2]) begin
      item2  <= item1;
      secs2  <= secs1;
      msrem2 <= 10'(17'(item1.elapsed_ms) - ms_back);
    end
    if (adv[3]) begin
      item3  <= item2;
      whole3 <= ccc_pkg::AMOUNT_W'(rate * ccc_pkg::AMOUNT_W'(secs2));
      frac3  <= 30'(rate) * 30'(msrem2);
    end
    if (adv[4]) begin
      item4   <= item3;
      amount4 <= scaled;
    end
  end

endmodule

FILE: sv/charge_connector_controller_top.sv
// Charge connector controller: connector state machine with energy metering.
// Path from an accepted item to a valid result: five scaling registers, the last
// one feeding the state update that loads the result register.
// Throughput: one transaction per cycle while results are taken; the state update stage is the only loop.
// Reset: synchronous, clears state, meters and config (auth timeout to 10000).
module charge_connector_controller_top #(
  parameter int METER_WIDTH = ccc_pkg::METER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  ccc_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output ccc_pkg::result_t                  result,
  input  logic                              write_enable,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]     write_index,
  input  logic [ccc_pkg::START_W-1:0]       write_data
);

  logic [ccc_pkg::RATE_W-1:0]    rate;
  logic [ccc_pkg::TIMEOUT_W-1:0] auth_timeout;

  ccc_pkg::conn_state_t conn_state, conn_state_next;
  logic                 auth_armed, auth_armed_next;
  logic [ccc_pkg::AUTH_W-1:0] auth_elapsed, auth_elapsed_next;
  logic                 timing_started, timing_started_next;
  logic [METER_WIDTH-1:0] total_meter, total_meter_next;
  logic [31:0]          session_meter, session_meter_next;
  logic [31:0]          session_limit, session_limit_next;
  logic [31:0]          session_id, session_id_next;

  logic                         sc_valid;
  logic                         sc_ready;
  ccc_pkg::item_t               sc_item;
  logic [ccc_pkg::AMOUNT_W-1:0] sc_amount;
  logic                         fire;

  ccc_pkg::conn_state_t         mid_state;
  logic                         cleared;
  logic [ccc_pkg::AMOUNT_W-1:0] amount;
  logic [ccc_pkg::AMOUNT_W-1:0] amount_try;
  logic [ccc_pkg::AUTH_W-1:0]   auth_sum;
  logic [31:0]                  remain;
  logic [31:0]                  avail;
  logic [31:0]                  power_w;
  logic [31:0]                  possible;
  logic [METER_WIDTH:0]         total_sum;
  logic [32:0]                  session_sum;
  logic [63:0]                  total_wide;

  ccc_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .rate       (rate),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (sc_valid),
    .out_ready  (sc_ready),
    .out_item   (sc_item),
    .out_amount (sc_amount)
  );

  assign sc_ready = !result_valid || result_ready;
  assign fire     = sc_valid && sc_ready;

  assign total_wide = 64'(total_meter_next);

  always_comb begin
    conn_state_next     = conn_state;
    auth_armed_next     = auth_armed;
    auth_elapsed_next   = auth_elapsed;
    timing_started_next = timing_started;
    total_meter_next    = total_meter;
    session_meter_next  = session_meter;
    session_limit_next  = session_limit;
    session_id_next     = session_id;
    mid_state           = conn_state;
    cleared             = 1'b0;
    amount              = '0;
    total_sum           = '0;
    session_sum         = '0;

    auth_sum = auth_elapsed + ccc_pkg::AUTH_W'(sc_item.elapsed_ms);
    power_w  = 32'(sc_item.car_power);
    remain   = (session_limit > session_meter) ? session_limit - session_meter : '0;
    avail    = (session_limit != '0) ? remain : power_w;
    possible = (avail < power_w) ? avail : power_w;
    amount_try = timing_started ? sc_amount : '0;

    unique case (sc_item.mode)
      ccc_pkg::MODE_POWER_GOOD:  conn_state_next = ccc_pkg::ST_ONPOST;
      ccc_pkg::MODE_POWER_FAULT: conn_state_next = ccc_pkg::ST_FAULT;
      ccc_pkg::MODE_ENROLL: begin
        session_id_next    = sc_item.session_number;
        session_limit_next = sc_item.session_cap;
        session_meter_next = '0;
        if (conn_state == ccc_pkg::ST_PLUGGED) begin
          conn_state_next = ccc_pkg::ST_CHARGING;
          auth_armed_next = 1'b0;
        end else if (conn_state != ccc_pkg::ST_FAULT && conn_state != ccc_pkg::ST_CHARGING &&
                     conn_state != ccc_pkg::ST_DONE) begin
          conn_state_next   = ccc_pkg::ST_AUTH;
          auth_armed_next   = 1'b1;
          auth_elapsed_next = '0;
        end
      end
      ccc_pkg::MODE_PLUG_IN: begin
        if (conn_state == ccc_pkg::ST_AUTH) begin
          conn_state_next = ccc_pkg::ST_CHARGING;
          auth_armed_next = 1'b0;
        end else begin
          conn_state_next = ccc_pkg::ST_PLUGGED;
        end
      end
      ccc_pkg::MODE_UNPLUG: conn_state_next = ccc_pkg::ST_ONPOST;
      ccc_pkg::MODE_FORCE_STOP: begin
        if (conn_state == ccc_pkg::ST_CHARGING) begin
          conn_state_next = ccc_pkg::ST_DONE;
        end else if (conn_state == ccc_pkg::ST_AUTH) begin
          conn_state_next = ccc_pkg::ST_ONPOST;
          auth_armed_next = 1'b0;
          cleared         = 1'b1;
        end
      end
      ccc_pkg::MODE_TICK: begin
        if (auth_armed) begin
          auth_elapsed_next = auth_sum;
          if (auth_sum >= ccc_pkg::AUTH_W'(auth_timeout)) begin
            auth_armed_next   = 1'b0;
            auth_elapsed_next = '0;
            if (conn_state == ccc_pkg::ST_AUTH) begin
              mid_state = ccc_pkg::ST_ONPOST;
              cleared   = 1'b1;
            end
          end
        end
        conn_state_next = mid_state;
        if (mid_state == ccc_pkg::ST_CHARGING) begin
          timing_started_next = 1'b1;
          // possible never exceeds car power, so it fits the amount width
          amount = (ccc_pkg::AMOUNT_W'(possible) < amount_try) ?
                   ccc_pkg::AMOUNT_W'(possible) : amount_try;
          total_sum   = {1'b0, total_meter} + (METER_WIDTH+1)'(amount);
          session_sum = {1'b0, session_meter} + 33'(amount);
          total_meter_next   = total_sum[METER_WIDTH] ? '1 : total_sum[METER_WIDTH-1:0];
          session_meter_next = session_sum[32] ? '1 : session_sum[31:0];
          if (possible == '0) conn_state_next = ccc_pkg::ST_DONE;
        end else begin
          timing_started_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate           <= '0;
      auth_timeout   <= ccc_pkg::AUTH_TIMEOUT_RST;
      conn_state     <= ccc_pkg::ST_UNDEF;
      auth_armed     <= 1'b0;
      auth_elapsed   <= '0;
      timing_started <= 1'b0;
      total_meter    <= '0;
      session_meter  <= '0;
      session_limit  <= '0;
      session_id     <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (fire) begin
        conn_state     <= conn_state_next;
        auth_armed     <= auth_armed_next;
        auth_elapsed   <= auth_elapsed_next;
        timing_started <= timing_started_next;
        total_meter    <= total_meter_next;
        session_meter  <= session_meter_next;
        session_limit  <= session_limit_next;
        session_id     <= session_id_next;
      end
      if (sc_ready) result_valid <= sc_valid;
      if (write_enable) begin
        unique case (write_index)
          ccc_pkg::CFG_RATE:         rate <= write_data[ccc_pkg::RATE_W-1:0];
          // the start value only matters as the load value of the total meter
          ccc_pkg::CFG_METER_START:  total_meter <= METER_WIDTH'(write_data);
          ccc_pkg::CFG_AUTH_TIMEOUT: auth_timeout <= write_data[ccc_pkg::TIMEOUT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.connector_state <= conn_state_next;
      result.auth_cleared    <= cleared;
      result.delivered       <= amount;
      result.meter_total     <= total_wide[47:0];
      result.session_energy  <= session_meter_next;
      result.session_out     <= session_id_next;
    end
  end

endmodule

FILE: sv/ccc_checker.sv
// Port-level assertions for the charge connector controller, bound to the top level.
module ccc_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input ccc_pkg::result_t result
);

  a_reset_clears_valid: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_cleared_on_post: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.auth_cleared |-> result.connector_state == ccc_pkg::ST_ONPOST)
    else $error("authorization cleared but connector not on post");

  a_energy_only_charging: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.delivered != '0 |->
      result.connector_state == ccc_pkg::ST_CHARGING)
    else $error("energy delivered outside charging");

endmodule

bind charge_connector_controller_top ccc_checker u_ccc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: test/tb_charge_connector_controller_top.sv
// Testbench for charge_connector_controller_top: event stimulus, connector/meter predictor, checks.
`timescale 1ns / 1ps

module tb_charge_connector_controller_top;

  localparam logic [2:0]   MODE_UNKNOWN = 3'd7;
  localparam logic [47:0]  METER_FULL   = '1;
  localparam int           HOLD_CYCLES  = 150;
  localparam int           STALL_LIMIT  = 2000;
  localparam int           DRAIN_CYCLES = 20;
  localparam int           REPORT_LIMIT = 10;
  localparam int           PHASE_ITEMS  = 150;
  localparam int           RANDOM_PHASES = 7;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          item_valid = 1'b0;
  logic                          item_ready;
  ccc_pkg::item_t                item_in = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  ccc_pkg::result_t              result_out;
  logic                          write_enable = 1'b0;
  logic [ccc_pkg::CFG_IDX_W-1:0] write_index = '0;
  logic [ccc_pkg::START_W-1:0]   write_data = '0;

  // predicted connector state and registers
  ccc_pkg::conn_state_t          conn_st;
  logic                          auth_on;
  logic [ccc_pkg::AUTH_W-1:0]    auth_ms;
  logic                          charge_timing;
  logic [47:0]                   total_e;
  logic [31:0]                   session_e;
  logic [31:0]                   session_lim;
  logic [31:0]                   session_tag;
  logic [ccc_pkg::RATE_W-1:0]    rate_cfg;
  logic [ccc_pkg::TIMEOUT_W-1:0] timeout_cfg;

  ccc_pkg::item_t   pending_events[$];
  ccc_pkg::result_t expected_results[$];
  ccc_pkg::result_t want_res;

  bit offering = 1'b0;
  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int failures = 0;
  int results_seen = 0;
  int queued_count = 0;
  int quiet_cycles = 0;

  charge_connector_controller_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_out),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic ccc_pkg::result_t predict_event(ccc_pkg::item_t ev);
    ccc_pkg::result_t r;
    logic [63:0]      amount;
    logic [63:0]      avail;
    logic [63:0]      possible;
    logic             cleared;
    cleared = 1'b0;
    amount = '0;
    case (ev.mode)
      ccc_pkg::MODE_POWER_GOOD: conn_st = ccc_pkg::ST_ONPOST;
      ccc_pkg::MODE_POWER_FAULT: conn_st = ccc_pkg::ST_FAULT;
      ccc_pkg::MODE_ENROLL: begin
        session_tag = ev.session_number;
        session_lim = ev.session_cap;
        session_e = '0;
        if (conn_st == ccc_pkg::ST_PLUGGED) begin
          conn_st = ccc_pkg::ST_CHARGING;
          auth_on = 1'b0;
        end else if (conn_st != ccc_pkg::ST_FAULT && conn_st != ccc_pkg::ST_CHARGING &&
                     conn_st != ccc_pkg::ST_DONE) begin
          conn_st = ccc_pkg::ST_AUTH;
          auth_on = 1'b1;
          auth_ms = '0;
        end
      end
      ccc_pkg::MODE_PLUG_IN: begin
        if (conn_st == ccc_pkg::ST_AUTH) begin
          conn_st = ccc_pkg::ST_CHARGING;
          auth_on = 1'b0;
        end else begin
          conn_st = ccc_pkg::ST_PLUGGED;
        end
      end
      ccc_pkg::MODE_UNPLUG: conn_st = ccc_pkg::ST_ONPOST;
      ccc_pkg::MODE_FORCE_STOP: begin
        if (conn_st == ccc_pkg::ST_CHARGING) begin
          conn_st = ccc_pkg::ST_DONE;
        end else if (conn_st == ccc_pkg::ST_AUTH) begin
          conn_st = ccc_pkg::ST_ONPOST;
          auth_on = 1'b0;
          cleared = 1'b1;
        end
      end
      ccc_pkg::MODE_TICK: begin
        if (auth_on) begin
          auth_ms = auth_ms + ccc_pkg::AUTH_W'(ev.elapsed_ms);
          if (auth_ms >= {1'b0, timeout_cfg}) begin
            auth_on = 1'b0;
            auth_ms = '0;
            if (conn_st == ccc_pkg::ST_AUTH) begin
              conn_st = ccc_pkg::ST_ONPOST;
              cleared = 1'b1;
            end
          end
        end
        if (conn_st == ccc_pkg::ST_CHARGING) begin
          // first tick of a charge only starts the timing
          if (!charge_timing) begin
            charge_timing = 1'b1;
          end else begin
            amount = (64'(rate_cfg) * 64'(ev.elapsed_ms)) / 64'(ccc_pkg::MS_PER_S);
            if (ev.car_power < ccc_pkg::PWR_LVL_HI) amount = amount >> 1;
            if (ev.car_power < ccc_pkg::PWR_LVL_MID) amount = amount >> 1;
            if (ev.car_power < ccc_pkg::PWR_LVL_LO) amount = amount >> 1;
          end
          if (session_lim != 0)
            avail = (session_lim > session_e) ? 64'(session_lim - session_e) : 64'd0;
          else
            avail = 64'(ev.car_power);
          possible = (avail < 64'(ev.car_power)) ? avail : 64'(ev.car_power);
          if (possible < amount) amount = possible;
          if (64'(METER_FULL) - 64'(total_e) < amount) total_e = METER_FULL;
          else total_e = total_e + amount[47:0];
          if (64'(session_e) + amount > 64'hFFFF_FFFF) session_e = '1;
          else session_e = session_e + amount[31:0];
          if (possible == 0) conn_st = ccc_pkg::ST_DONE;
        end else begin
          charge_timing = 1'b0;
        end
      end
      default: ;
    endcase
    r.connector_state = conn_st;
    r.auth_cleared = cleared;
    r.delivered = amount[ccc_pkg::AMOUNT_W-1:0];
    r.meter_total = total_e;
    r.session_energy = session_e;
    r.session_out = session_tag;
    return r;
  endfunction

  function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, field, want, got);
  endfunction

  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      3: return 16'($urandom_range(0, 200));
      default: return 16'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [ccc_pkg::RATE_W-1:0] pick_power();
    case ($urandom_range(0, 5))
      0: return ccc_pkg::RATE_W'($urandom);
      1: return '0;
      2: begin
        case ($urandom_range(0, 5))
          0: return ccc_pkg::PWR_LVL_LO - 20'd1;
          1: return ccc_pkg::PWR_LVL_LO;
          2: return ccc_pkg::PWR_LVL_MID - 20'd1;
          3: return ccc_pkg::PWR_LVL_MID;
          4: return ccc_pkg::PWR_LVL_HI - 20'd1;
          default: return ccc_pkg::PWR_LVL_HI;
        endcase
      end
      default: return ccc_pkg::RATE_W'($urandom_range(0, 2500));
    endcase
  endfunction

  function automatic logic [31:0] pick_cap();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return $urandom_range(1, 3000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_event(logic [2:0] mode, logic [31:0] number, logic [31:0] cap,
                             logic [15:0] ms, logic [ccc_pkg::RATE_W-1:0] power);
    ccc_pkg::item_t it;
    it.mode = mode;
    it.session_number = number;
    it.session_cap = cap;
    it.elapsed_ms = ms;
    it.car_power = power;
    pending_events.push_back(it);
    queued_count++;
  endtask

  task automatic queue_simple(logic [2:0] mode);
    queue_event(mode, $urandom, $urandom, 16'($urandom), ccc_pkg::RATE_W'($urandom));
  endtask

  task automatic queue_enroll();
    queue_event(ccc_pkg::MODE_ENROLL, $urandom, pick_cap(), 16'($urandom),
                ccc_pkg::RATE_W'($urandom));
  endtask

  // well-formed charge: authorize and plug in either order, ticks, then possibly an ending
  task automatic queue_charge();
    int n;
    if ($urandom_range(0, 3) == 0) queue_simple(ccc_pkg::MODE_POWER_GOOD);
    if ($urandom_range(0, 1) == 1) begin
      queue_enroll();
      queue_simple(ccc_pkg::MODE_PLUG_IN);
    end else begin
      queue_simple(ccc_pkg::MODE_PLUG_IN);
      queue_enroll();
    end
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0: queue_simple(ccc_pkg::MODE_FORCE_STOP);
        1: queue_enroll();
        2: queue_simple(ccc_pkg::MODE_PLUG_IN);
        default: queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, pick_ms(), pick_power());
      endcase
    end
    case ($urandom_range(0, 3))
      0: queue_simple(ccc_pkg::MODE_UNPLUG);
      1: begin
        queue_simple(ccc_pkg::MODE_FORCE_STOP);
        queue_simple(ccc_pkg::MODE_UNPLUG);
      end
      2: queue_simple(ccc_pkg::MODE_POWER_FAULT);
      default: ;
    endcase
  endtask

  // authorization left to age out
  task automatic queue_auth_wait();
    int n;
    queue_enroll();
    n = $urandom_range(1, 5);
    repeat (n)
      queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom,
                  16'($urandom_range(0, timeout_cfg)), pick_power());
    if ($urandom_range(0, 2) == 0) queue_simple(ccc_pkg::MODE_FORCE_STOP);
  endtask

  task automatic write_reg(ccc_pkg::cfg_idx_t idx, logic [ccc_pkg::START_W-1:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      ccc_pkg::CFG_RATE: rate_cfg = val[ccc_pkg::RATE_W-1:0];
      ccc_pkg::CFG_METER_START: total_e = val;
      ccc_pkg::CFG_AUTH_TIMEOUT: timeout_cfg = val[ccc_pkg::TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [ccc_pkg::RATE_W-1:0] rate,
                           logic [ccc_pkg::START_W-1:0] start,
                           logic [ccc_pkg::TIMEOUT_W-1:0] timeout);
    write_reg(ccc_pkg::CFG_RATE, ccc_pkg::START_W'(rate));
    write_reg(ccc_pkg::CFG_METER_START, start);
    write_reg(ccc_pkg::CFG_AUTH_TIMEOUT, ccc_pkg::START_W'(timeout));
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || offering || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      offering = 1'b0;
      gap_left = 0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.push_back(predict_event(item_in));
        offering = 1'b0;
        gap_left = calm ? 0 : $urandom_range(0, 10);
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_events.size() != 0) begin
          item_in <= pending_events.pop_front();
          offering = 1'b1;
        end
      end
      item_valid <= offering;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("result %0d: 0x%0h with no transaction pending", results_seen, result_out);
        end else begin
          want_res = expected_results.pop_front();
          if (result_out.connector_state !== want_res.connector_state)
            note_mismatch("connector_state", 64'(want_res.connector_state),
                          64'(result_out.connector_state));
          if (result_out.auth_cleared !== want_res.auth_cleared)
            note_mismatch("auth_cleared", 64'(want_res.auth_cleared),
                          64'(result_out.auth_cleared));
          if (result_out.delivered !== want_res.delivered)
            note_mismatch("delivered", 64'(want_res.delivered), 64'(result_out.delivered));
          if (result_out.meter_total !== want_res.meter_total)
            note_mismatch("meter_total", 64'(want_res.meter_total),
                          64'(result_out.meter_total));
          if (result_out.session_energy !== want_res.session_energy)
            note_mismatch("session_energy", 64'(want_res.session_energy),
                          64'(result_out.session_energy));
          if (result_out.session_out !== want_res.session_out)
            note_mismatch("session_out", 64'(want_res.session_out),
                          64'(result_out.session_out));
        end
        stall_left = calm ? 0 : $urandom_range(0, 10);
      end
      if (hold_left == 0 && holds_granted != hold_requests) begin
        holds_granted++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int                            pick;
    logic [ccc_pkg::RATE_W-1:0]    rate_pick;
    logic [ccc_pkg::START_W-1:0]   start_pick;
    logic [ccc_pkg::TIMEOUT_W-1:0] timeout_pick;
    rate_cfg = '0;
    timeout_cfg = ccc_pkg::AUTH_TIMEOUT_RST;
    conn_st = ccc_pkg::ST_UNDEF;
    auth_on = 1'b0;
    auth_ms = '0;
    charge_timing = 1'b0;
    total_e = '0;
    session_e = '0;
    session_lim = '0;
    session_tag = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: full rate, total meter just below saturation, longest timeout
    configure('1, METER_FULL - 48'd1000, '1);
    queue_simple(MODE_UNKNOWN);
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, '0, '0);
    queue_simple(ccc_pkg::MODE_POWER_FAULT);
    queue_event(ccc_pkg::MODE_ENROLL, '1, '0, '1, '1);
    queue_simple(ccc_pkg::MODE_POWER_GOOD);
    queue_event(ccc_pkg::MODE_ENROLL, '0, '0, '0, '0);
    queue_event(ccc_pkg::MODE_TICK, '0, '0, '1, '1);       // timeout reached exactly
    queue_enroll();
    queue_simple(ccc_pkg::MODE_FORCE_STOP);                // drops the authorization
    queue_simple(ccc_pkg::MODE_PLUG_IN);
    queue_event(ccc_pkg::MODE_ENROLL, $urandom, '0, '0, '0);
    queue_event(ccc_pkg::MODE_TICK, '0, '0, '1, '1);       // first tick meters nothing
    queue_event(ccc_pkg::MODE_TICK, '1, '1, '1, '1);       // total meter saturates
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, 16'd1000,
                ccc_pkg::PWR_LVL_HI - 20'd1);
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, 16'd1000, '0);  // no power: done
    queue_simple(ccc_pkg::MODE_FORCE_STOP);
    queue_simple(ccc_pkg::MODE_UNPLUG);
    drain();

    // directed: zero timeout expires on the first tick, small session limit
    configure(20'd100000, '0, '0);
    queue_event(ccc_pkg::MODE_ENROLL, $urandom, 32'd7, '0, '0);
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, '0, '1);
    queue_simple(ccc_pkg::MODE_PLUG_IN);
    queue_event(ccc_pkg::MODE_ENROLL, $urandom, 32'd7, '0, '0);
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, 16'd10, ccc_pkg::PWR_LVL_HI - 20'd1);
    // capped by limit
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, 16'd10, ccc_pkg::PWR_LVL_HI - 20'd1);
    // limit used up
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, 16'd10, ccc_pkg::PWR_LVL_HI - 20'd1);
    queue_simple(ccc_pkg::MODE_PLUG_IN);
    queue_event(ccc_pkg::MODE_ENROLL, $urandom, '0, '0, '0);
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, 16'd10, ccc_pkg::PWR_LVL_MID - 20'd1);
    queue_event(ccc_pkg::MODE_TICK, $urandom, $urandom, 16'd10, ccc_pkg::PWR_LVL_LO - 20'd1);
    queue_simple(ccc_pkg::MODE_FORCE_STOP);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      calm = (p == 2);
      case (p)
        0: rate_pick = '1;
        3: rate_pick = ccc_pkg::RATE_W'($urandom_range(0, 3000));
        5: rate_pick = '0;
        default: rate_pick = ccc_pkg::RATE_W'($urandom);
      endcase
      case (p)
        1: start_pick = METER_FULL;
        6: start_pick = '0;
        default: start_pick = {$urandom, $urandom};
      endcase
      case (p)
        0: timeout_pick = 16'd1;
        3: timeout_pick = '1;
        default: timeout_pick = 16'($urandom_range(1, 20000));
      endcase
      configure(rate_pick, start_pick, timeout_pick);
      queued_count = 0;
      while (queued_count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) queue_charge();
        else if (pick < 8) queue_auth_wait();
        else repeat ($urandom_range(1, 3)) queue_simple(3'($urandom_range(0, 7)));
      end
      // long receiver stall while the sender keeps offering
      if (p == 4) hold_requests++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
sv/ccc_pkg.sv
sv/ccc_scale.sv
sv/charge_connector_controller_top.sv
sv/ccc_checker.sv
test/tb_charge_connector_controller_top.sv
